/* src/cps3_pkg.sv */
// ----------------------------------------------------------------------------
// Closest point on segment: shared types
// Region codes for the nearest-point result.
// ----------------------------------------------------------------------------
package cps3_pkg;

    typedef enum logic [1:0] {
        REG_INTERIOR = 2'd0,
        REG_START    = 2'd1,
        REG_END      = 2'd2,
        REG_DEGEN    = 2'd3
    } t_region;

endpackage

/* src/cps3_div.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; accepts a new operand pair each cycle.
// Carries a side payload alongside. Stalls with the global enable.
// ----------------------------------------------------------------------------
module cps3_div #(
    parameter int NB = 8,
    parameter int QB = 4,
    parameter int PB = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NB-1:0] i_num,
    input  logic [NB-1:0] i_den,
    input  logic [PB-1:0] i_pay,
    output logic          o_valid,
    output logic [QB-1:0] o_quo,
    output logic [PB-1:0] o_pay
);

    logic [NB-1:0] r_rem [QB];
    logic [NB-1:0] r_den [QB];
    logic [QB-1:0] r_quo [QB];
    logic [PB-1:0] r_pay [QB];
    logic          r_vld [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;
        logic [NB-1:0]    w_rem;
        logic [NB-1:0]    w_den;
        logic [QB-1:0]    w_quo;
        logic [PB-1:0]    w_pay;
        logic             w_vld;
        logic [NB+QB-1:0] n_trial;
        logic             n_fit;
        if (k == 0) begin : g_src
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_quo = '0;
            assign w_pay = i_pay;
            assign w_vld = i_valid;
        end else begin : g_src
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
            assign w_pay = r_pay[k-1];
            assign w_vld = r_vld[k-1];
        end
        always_comb begin
            n_trial = {{QB{1'b0}}, w_den} << SH;
            n_fit   = {{QB{1'b0}}, w_rem} >= n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
            if (i_en) begin
                r_rem[k] <= n_fit ? w_rem - n_trial[NB-1:0] : w_rem;
                r_den[k] <= w_den;
                r_quo[k] <= w_quo | (QB'(n_fit) << SH);
                r_pay[k] <= w_pay;
            end
        end
    end

    assign o_valid = r_vld[QB-1];
    assign o_quo   = r_quo[QB-1];
    assign o_pay   = r_pay[QB-1];

endmodule

/* src/closest_point_on_segment_3d.sv */
// ----------------------------------------------------------------------------
// Closest point on a 3D segment
// Streaming nearest-point projection with region code.
// ----------------------------------------------------------------------------
// One beat in, one beat out, a new beat every cycle while not stalled. With
// C = COORD_BITS there are four front stages for differences, products, sums
// and the rounding numerator, then the per-axis restoring divider pipeline of
// C + 1 quotient stages, then the output register. The whole chain advances
// only when the output register is free or being taken, so a stall holds
// every beat in place. Interior results round to nearest, ties away from zero.
module closest_point_on_segment_3d
    import cps3_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 4,
    localparam int TDW_IN  = ((9*COORD_BITS + 7) / 8) * 8,
    localparam int TDW_OUT = ((3*COORD_BITS + 2 + 7) / 8) * 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // point_x,y,z, start_x,y,z, end_x,y,z from bit 0 up
    input  logic [TDW_IN-1:0]         s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // near_x, near_y, near_z, region from bit 0 up
    output logic [TDW_OUT-1:0]        m_axis_tdata
);
    localparam int C  = COORD_BITS;
    localparam int DW = C + 1;           // difference width
    localparam int PW = 2*DW;            // product width
    localparam int SW = PW + 2;          // dot sum width
    localparam int NW = SW + DW + 1;     // 2*|d|*num + den width
    localparam int QW = DW;              // quotient width (q <= |d|)
    localparam int PAYW = 3*C + 3*C + 2 + 3;
    // fraction bits cancel in num/den; carried for interface documentation
    localparam int UNUSED_FRAC = FRAC_BITS;

    logic w_adv;
    logic r_ovld;
    assign w_adv         = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_adv;

    // stage 1: differences
    logic signed [C-1:0]  w_p [3], w_s [3], w_e [3];
    logic                 r1_v;
    logic signed [DW-1:0] r1_d [3], r1_a [3];
    logic signed [C-1:0]  r1_s [3], r1_e [3];
    for (genvar i = 0; i < 3; i++) begin : g_s1
        assign w_p[i] = s_axis_tdata[i*C +: C];
        assign w_s[i] = s_axis_tdata[(3+i)*C +: C];
        assign w_e[i] = s_axis_tdata[(6+i)*C +: C];
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r1_d[i] <= DW'(w_e[i]) - DW'(w_s[i]);
                r1_a[i] <= DW'(w_p[i]) - DW'(w_s[i]);
                r1_s[i] <= w_s[i];
                r1_e[i] <= w_e[i];
            end
        end
    end

    // stage 2: products
    logic                 r2_v;
    logic signed [PW-1:0] r2_ad [3], r2_dd [3];
    logic signed [DW-1:0] r2_d [3];
    logic signed [C-1:0]  r2_s [3], r2_e [3];
    for (genvar i = 0; i < 3; i++) begin : g_s2
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r2_ad[i] <= PW'(r1_a[i]) * PW'(r1_d[i]);
                r2_dd[i] <= PW'(r1_d[i]) * PW'(r1_d[i]);
                r2_d[i]  <= r1_d[i];
                r2_s[i]  <= r1_s[i];
                r2_e[i]  <= r1_e[i];
            end
        end
    end

    // stage 3: dot products
    logic                 r3_v;
    logic signed [SW-1:0] r3_num, r3_den;
    logic signed [DW-1:0] r3_d [3];
    logic signed [C-1:0]  r3_s [3], r3_e [3];
    logic signed [SW-1:0] n3_num, n3_den;
    always_comb begin
        n3_num = SW'(r2_ad[0]) + SW'(r2_ad[1]) + SW'(r2_ad[2]);
        n3_den = SW'(r2_dd[0]) + SW'(r2_dd[1]) + SW'(r2_dd[2]);
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_num <= n3_num;
            r3_den <= n3_den;
            r3_d   <= r2_d;
            r3_s   <= r2_s;
            r3_e   <= r2_e;
        end
    end

    // stage 4: region, magnitude products 2*|d|*num + den
    logic                 r4_v;
    t_region              r4_reg;
    logic [NW-1:0]        r4_n [3];
    logic [NW-1:0]        r4_dv;
    logic [2:0]           r4_neg;
    logic signed [C-1:0]  r4_s [3], r4_e [3];
    t_region              n4_reg;
    always_comb begin
        priority if (r3_den == '0)      n4_reg = REG_DEGEN;
        else if (r3_num <= SW'(0))      n4_reg = REG_START;
        else if (r3_num >= r3_den)      n4_reg = REG_END;
        else                            n4_reg = REG_INTERIOR;
    end
    for (genvar i = 0; i < 3; i++) begin : g_s4
        logic [DW-1:0] w_mag;
        assign w_mag = r3_d[i][DW-1] ? DW'(-r3_d[i]) : DW'(r3_d[i]);
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r4_n[i]   <= ((NW'(w_mag) * NW'(r3_num[SW-1:0])) << 1) + NW'(r3_den[SW-1:0]);
                r4_neg[i] <= r3_d[i][DW-1];
                r4_s[i]   <= r3_s[i];
                r4_e[i]   <= r3_e[i];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_reg <= n4_reg;
            r4_dv  <= NW'(r3_den[SW-1:0]) << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_adv) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // divider lanes; lane 0 carries the selection payload
    logic [PAYW-1:0] w_pay, w_pay_o;
    logic [QW-1:0]   w_q [3];
    logic [2:0]      w_dv;
    assign w_pay = {r4_neg, r4_reg, r4_e[2], r4_e[1], r4_e[0],
                    r4_s[2], r4_s[1], r4_s[0]};
    for (genvar i = 0; i < 3; i++) begin : g_div
        logic [PAYW-1:0] w_po;
        cps3_div #(.NB(NW), .QB(QW), .PB(PAYW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (r4_v),
            .i_num   (r4_n[i]),
            .i_den   (r4_dv),
            .i_pay   (i == 0 ? w_pay : '0),
            .o_valid (w_dv[i]),
            .o_quo   (w_q[i]),
            .o_pay   (w_po)
        );
        if (i == 0) begin : g_p
            assign w_pay_o = w_po;
        end
    end

    // output register: pick start, end or start +/- q
    logic [C-1:0]  w_os [3], w_oe [3];
    logic [2:0]    w_oneg;
    t_region       w_oreg;
    logic [C-1:0]  n_near [3];
    logic [TDW_OUT-1:0] r_odata;
    assign w_oneg = w_pay_o[PAYW-1 -: 3];
    assign w_oreg = t_region'(w_pay_o[6*C +: 2]);
    for (genvar i = 0; i < 3; i++) begin : g_sel
        assign w_os[i] = w_pay_o[i*C +: C];
        assign w_oe[i] = w_pay_o[(3+i)*C +: C];
        always_comb begin
            unique case (w_oreg)
                REG_END:      n_near[i] = w_oe[i];
                REG_INTERIOR: n_near[i] = w_oneg[i] ? w_os[i] - C'(w_q[i])
                                                    : w_os[i] + C'(w_q[i]);
                default:      n_near[i] = w_os[i];
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= w_dv[0];
        end
        if (w_adv) begin
            r_odata <= TDW_OUT'({w_oreg, n_near[2], n_near[1], n_near[0]});
        end
    end
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    // output beat must hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !m_axis_tready |=> r_ovld && $stable(r_odata))
        else $error("output beat changed under stall");
    // lanes stay in step
    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv[0] == w_dv[1] && w_dv[1] == w_dv[2])
        else $error("divider lanes out of step");
    // input stays open whenever the output register is empty
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_fr: assert property (@(posedge i_clk) UNUSED_FRAC >= 0)
        else $error("bad fraction width");

endmodule

/* sim/cps3_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest-point checker
// Watches both stream channels and predicts each result from the input beat.
// Compares every output beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module cps3_checker
    import cps3_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [143:0] i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [55:0]  i_out_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        t_region     region;
    } t_nearest;

    t_nearest nearest_q[$];
    int       report_count;

    function automatic t_nearest project_point(logic [143:0] beat);
        t_nearest    r;
        longint      p[3], s[3], e[3], d[3], a[3];
        longint      num, den, q, md;
        logic [15:0] near[3];
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(beat[16*i +: 16]));
            s[i] = longint'($signed(beat[16*(i+3) +: 16]));
            e[i] = longint'($signed(beat[16*(i+6) +: 16]));
            d[i] = e[i] - s[i];
            a[i] = p[i] - s[i];
            num += a[i] * d[i];
            den += d[i] * d[i];
        end
        if (den == 0) begin
            r.region = REG_DEGEN;
            for (int i = 0; i < 3; i++) near[i] = s[i][15:0];
        end else if (num <= 0) begin
            r.region = REG_START;
            for (int i = 0; i < 3; i++) near[i] = s[i][15:0];
        end else if (num >= den) begin
            r.region = REG_END;
            for (int i = 0; i < 3; i++) near[i] = e[i][15:0];
        end else begin
            r.region = REG_INTERIOR;
            for (int i = 0; i < 3; i++) begin
                md = (d[i] < 0) ? -d[i] : d[i];
                // round to nearest, ties away from zero
                q = (2 * md * num + den) / (2 * den);
                near[i] = (d[i] < 0) ? 16'(s[i] - q) : 16'(s[i] + q);
            end
        end
        r.nx = near[0];
        r.ny = near[1];
        r.nz = near[2];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_nearest want;
        t_nearest got;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_pending    <= 0;
            report_count = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                nearest_q.push_back(project_point(i_in_data));
            if (i_out_valid && i_out_ready) begin
                got.nx     = i_out_data[15:0];
                got.ny     = i_out_data[31:16];
                got.nz     = i_out_data[47:32];
                got.region = t_region'(i_out_data[49:48]);
                if (nearest_q.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (report_count < 10)
                        $display("unexpected beat: %h", i_out_data);
                    report_count++;
                end else begin
                    want = nearest_q.pop_front();
                    if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
                        got.region !== want.region) begin
                        o_fail_count <= o_fail_count + 1;
                        if (report_count < 10)
                            $display("mismatch: exp %h %h %h r%0d, got %h %h %h r%0d",
                                     want.nx, want.ny, want.nz, want.region,
                                     got.nx, got.ny, got.nz, got.region);
                        report_count++;
                    end
                end
            end
            o_pending <= nearest_q.size();
        end
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Nearest-point block testbench
// Directed corner beats, then random queries with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import cps3_pkg::*;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // point_x,y,z, start_x,y,z, end_x,y,z from bit 0 up
    logic [143:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // near_x, near_y, near_z, region (bits 49:48) from bit 0 up, zero filled
    logic [55:0]  m_axis_tdata;
    int           fail_count;
    int           pending;
    int           cycle_count = 0;
    int           beat_index;

    closest_point_on_segment_3d dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    cps3_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Generous watchdog: the slowest run is far below this.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stalls about 11 percent of the time, except for a quiet stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n || (cycle_count > 1500 && cycle_count < 2500))
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 11);
    end

    // Offer one beat and hold it until taken. Call at a rising edge.
    task automatic send_query(logic [15:0] c[9]);
        if ($urandom_range(99) < 11 && !(beat_index > 600 && beat_index < 800)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 11) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beat_index++;
    endtask

    // Coordinate order: point, start, end.
    task automatic send_coords(int px, int py, int pz, int sx, int sy, int sz,
                               int ex, int ey, int ez);
        logic [15:0] c[9];
        c = '{16'(px), 16'(py), 16'(pz), 16'(sx), 16'(sy), 16'(sz),
              16'(ex), 16'(ey), 16'(ez)};
        send_query(c);
    endtask

    function automatic int rand_coord(int span);
        if (span >= 32768)
            return $signed(16'($urandom));
        return $urandom_range(2 * span) - span;
    endfunction

    initial begin
        logic [15:0] c[9];
        int          span;
        beat_index    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // degenerate segment, at both extremes
        send_coords(5, -7, 9, 100, 200, 300, 100, 200, 300);
        send_coords(32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768);
        // before start and exactly at start
        send_coords(-50, 0, 0, 0, 0, 0, 100, 0, 0);
        send_coords(0, 0, 0, 0, 0, 0, 100, 0, 0);
        // beyond end and exactly at end
        send_coords(150, 3, 0, 0, 0, 0, 100, 0, 0);
        send_coords(100, 0, 0, 0, 0, 0, 100, 0, 0);
        // interior, plain and with halfway ties either sign of d
        send_coords(37, 20, -4, 0, 0, 0, 100, 0, 0);
        send_coords(1, 0, 0, 0, 0, 0, 1, 1, 0);
        send_coords(-1, 0, 0, 0, 0, 0, -1, -1, 0);
        send_coords(10, 11, 12, 20, 20, 20, 0, 0, 0);
        // full-range segments
        send_coords(0, 0, 0, -32768, -32768, -32768, 32767, 32767, 32767);
        send_coords(1, -1, 0, 32767, -32768, 32767, -32768, 32767, -32768);
        send_coords(-32768, 32767, -32768, -32768, -32768, -32768, 32767, 32767, 32767);
        send_coords(32767, 32767, 32767, 32767, -32768, 0, -32768, 32767, 0);
        send_coords(-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, -32768);

        for (int n = 0; n < 1250; n++) begin
            // sender waits once for the pipeline to drain completely
            if (n == 500) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            case ($urandom_range(3))
                0: span = 32768;
                1: span = 2000;
                2: span = 40;
                default: span = 3;
            endcase
            for (int k = 0; k < 9; k++) c[k] = 16'(rand_coord(span));
            // sometimes collapse the segment or put the point on it
            if ($urandom_range(19) == 0)
                for (int k = 6; k < 9; k++) c[k] = c[k-3];
            if ($urandom_range(19) == 0)
                for (int k = 0; k < 3; k++) c[k] = c[k+6];
            send_query(c);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
